// ===== rtl/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg
// shared constants, codes, types and helpers of the matrix multiply engine
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM   = 16;
  localparam int IDX_W     = 4;
  localparam int IDX_LIMIT = 2 ** IDX_W;
  localparam int DIM_CAP   = (MAX_DIM < IDX_LIMIT) ? MAX_DIM : IDX_LIMIT;
  localparam int DIM_W     = 5;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = 36;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef struct packed {
    logic valid;
    logic clear;
  } mac_ctl_t;

  typedef struct packed {
    logic             strobe;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } emit_t;

  // zero acts as one, anything above the cap acts as the cap
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = DIM_W'(1);
    end else if (v > DIM_W'(DIM_CAP)) begin
      d = DIM_W'(DIM_CAP);
    end else begin
      d = v;
    end
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

endpackage

// ===== rtl/mme_channels.sv =====
// ----------------------------------------------------------------------------
// mme channels
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface mme_cmd_if import mme_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [ELEM_W-1:0] element;

  modport source (output valid, op, row_index, col_index, element, input ready);
  modport sink   (input valid, op, row_index, col_index, element, output ready);
endinterface

interface mme_res_if import mme_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic                    last;

  modport source (output valid, sum, out_row, out_col, last, input ready);
  modport sink   (input valid, sum, out_row, out_col, last, output ready);
endinterface

// ===== rtl/mme_ram.sv =====
// ----------------------------------------------------------------------------
// mme_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mme_mac.sv =====
// ----------------------------------------------------------------------------
// mme_mac
// shared multiply-accumulate unit: registered product, then 36-bit sum
// ----------------------------------------------------------------------------
module mme_mac import mme_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [ELEM_W-1:0] a,
  input  logic signed [ELEM_W-1:0] b,
  output logic                     busy,
  output logic signed [SUM_W-1:0]  acc
);

  logic                     prod_v;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + SUM_W'(prod);
    end
  end

  assign busy = prod_v;

endmodule

// ===== rtl/mme_seq.sv =====
// ----------------------------------------------------------------------------
// mme_seq
// sequencer: walks columns and the inner dimension, drives store reads
// ----------------------------------------------------------------------------
module mme_seq import mme_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IDX_W-1:0]  start_row,
  input  logic [DIM_W-1:0]  nk,
  input  logic [DIM_W-1:0]  nc,
  input  logic              out_free,
  input  logic              mac_busy,
  output logic              idle,
  output logic [ADDR_W-1:0] a_addr,
  output logic [ADDR_W-1:0] b_addr,
  output mac_ctl_t          mac_ctl,
  output emit_t             emit
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]       state;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic             rd_v;
  logic             last_k;
  logic             last_j;
  logic             do_emit;

  assign last_k  = (DIM_W'(k) == nk - DIM_W'(1));
  assign last_j  = (DIM_W'(j) == nc - DIM_W'(1));
  assign do_emit = (state == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= (state == S_RUN);
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (last_k) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait until the last product has landed in the sum
          if (!rd_v && !mac_busy) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= last_j ? S_IDLE : S_RUN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      row <= start_row;
      j   <= '0;
      k   <= '0;
    end else if (state == S_RUN) begin
      k <= last_k ? '0 : k + IDX_W'(1);
    end else if (do_emit && !last_j) begin
      j <= j + IDX_W'(1);
    end
  end

  assign idle          = (state == S_IDLE);
  assign a_addr        = elem_addr(row, k);
  assign b_addr        = elem_addr(k, j);
  assign mac_ctl.valid = rd_v;
  assign mac_ctl.clear = (state == S_IDLE && start) || (do_emit && !last_j);
  assign emit.strobe   = do_emit;
  assign emit.row      = row;
  assign emit.col      = j;
  assign emit.last     = last_j;

endmodule

// ===== rtl/matrix_multiply_engine_core.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// dense matrix product over q8.8 elements with exact q20.16 row results
//
//   channel  dir  payload                            handshake
//   cmd      in   op, row_index, col_index, element  valid / ready
//   res      out  sum, out_row, out_col, last        valid / ready
//   cfg      in   cfg_index, cfg_data                cfg_wr_en
//
// a row request is paced by the single multiply-accumulate unit and one read
// port per store
// ready is low while a row is being worked; a stalled result holds the sequencer
// in its emit step, the output register still frees on the cycle it is taken
// synchronous reset sets the sizes to 16; the stores are not cleared
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core import mme_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  mme_cmd_if.sink              cmd,
  mme_res_if.source            res
);

  logic [DIM_W-1:0]         rows;
  logic [DIM_W-1:0]         inner;
  logic [DIM_W-1:0]         cols;
  logic [DIM_W-1:0]         nr;
  logic [DIM_W-1:0]         nk;
  logic [DIM_W-1:0]         nc;
  logic                     take;
  logic                     we_a;
  logic                     we_b;
  logic                     start;
  logic [ADDR_W-1:0]        waddr;
  logic [ADDR_W-1:0]        a_addr;
  logic [ADDR_W-1:0]        b_addr;
  logic signed [ELEM_W-1:0] a_data;
  logic signed [ELEM_W-1:0] b_data;
  logic                     idle;
  logic                     out_free;
  logic                     mac_busy;
  logic signed [SUM_W-1:0]  acc;
  mac_ctl_t                 mac_ctl;
  emit_t                    emit;
  logic                     out_valid;
  logic signed [SUM_W-1:0]  out_sum;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows  <= DIM_RESET;
      inner <= DIM_RESET;
      cols  <= DIM_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROWS:  rows  <= cfg_data;
        CFG_INNER: inner <= cfg_data;
        CFG_COLS:  cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nr = eff_dim(rows);
  assign nk = eff_dim(inner);
  assign nc = eff_dim(cols);

  assign cmd.ready = idle;
  assign take      = cmd.valid && cmd.ready;

  // out-of-range loads and requests are dropped here
  assign we_a  = take && (cmd.op == OP_LOAD_A) &&
                 (DIM_W'(cmd.row_index) < nr) && (DIM_W'(cmd.col_index) < nk);
  assign we_b  = take && (cmd.op == OP_LOAD_B) &&
                 (DIM_W'(cmd.row_index) < nk) && (DIM_W'(cmd.col_index) < nc);
  assign start = take && (cmd.op == OP_COMPUTE) && (DIM_W'(cmd.row_index) < nr);
  assign waddr = elem_addr(cmd.row_index, cmd.col_index);

  mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_left (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (cmd.element),
    .raddr (a_addr),
    .rdata (a_data)
  );

  mme_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_right (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (cmd.element),
    .raddr (b_addr),
    .rdata (b_data)
  );

  mme_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_row (cmd.row_index),
    .nk        (nk),
    .nc        (nc),
    .out_free  (out_free),
    .mac_busy  (mac_busy),
    .idle      (idle),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .mac_ctl   (mac_ctl),
    .emit      (emit)
  );

  mme_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (a_data),
    .b    (b_data),
    .busy (mac_busy),
    .acc  (acc)
  );

  // output register, refilled in the cycle the held word is taken
  assign out_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.strobe) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.strobe) begin
      out_sum  <= acc;
      out_row  <= emit.row;
      out_col  <= emit.col;
      out_last <= emit.last;
    end
  end

  assign res.valid   = out_valid;
  assign res.sum     = out_sum;
  assign res.out_row = out_row;
  assign res.out_col = out_col;
  assign res.last    = out_last;

endmodule

// ===== tb/sv/tb_matrix_multiply_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine_core
// checks the matrix multiply engine word by word: a directed table of loads,
// row requests and size writes, then randomised phases at several sizes, with
// bursty command traffic and a stalling result sink; every result word is
// compared with its table sum or a local model of the stores and q20.16 dot product
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine_core;
  import mme_pkg::*;

  localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int QUIET_CYCLES    = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int ITEMS_PER_PHASE = 52;
  localparam int NUM_DIRECTED    = 24;
  localparam int NUM_PHASES      = 6;

  localparam logic [DIM_W-1:0] PHASE_ROWS  [NUM_PHASES] = '{5'd2, 5'd31, 5'd1, 5'd5, 5'd16, 5'd4};
  localparam logic [DIM_W-1:0] PHASE_INNER [NUM_PHASES] = '{5'd4, 5'd2, 5'd16, 5'd0, 5'd3, 5'd1};
  localparam logic [DIM_W-1:0] PHASE_COLS  [NUM_PHASES] = '{5'd3, 5'd3, 5'd1, 5'd16, 5'd2, 5'd31};

  typedef enum logic {STEP_CMD, STEP_CFG} step_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_SHUT, RX_FLICKER} rx_mode_e;

  typedef struct packed {
    step_kind_e               kind;
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] elem;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [DIM_W-1:0]         reg_val;
    logic                     typed;
    logic [1:0]               n;
    logic signed [SUM_W-1:0]  s0;
    logic signed [SUM_W-1:0]  s1;
  } step_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } row_sum_t;

  // typed rows carry their expected sums, the rest go through the model
  localparam step_t DIRECTED_STEPS [NUM_DIRECTED] = '{
    '{STEP_CFG, OP_LOAD_A, 4'd0, 4'd0, 16'sh0000, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CFG, OP_LOAD_A, 4'd0, 4'd0, 16'sh0000, CFG_INNER, 5'd1, 1'b0, 2'd0, '0, '0},
    '{STEP_CFG, OP_LOAD_A, 4'd0, 4'd0, 16'sh0000, CFG_COLS, 5'd1, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_LOAD_A, 4'd0, 4'd0, 16'sh7fff, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_LOAD_B, 4'd0, 4'd0, 16'sh7fff, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_COMPUTE, 4'd0, 4'd0, 16'sh0000, CFG_ROWS, 5'd0, 1'b1, 2'd1,
      36'sd1073676289, '0},
    '{STEP_CMD, OP_LOAD_A, 4'd0, 4'd0, 16'sh8000, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_COMPUTE, 4'd0, 4'd0, 16'sh0000, CFG_ROWS, 5'd0, 1'b1, 2'd1,
      -36'sd1073709056, '0},
    '{STEP_CMD, OP_LOAD_B, 4'd0, 4'd0, 16'sh8000, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_COMPUTE, 4'd0, 4'd0, 16'sh0000, CFG_ROWS, 5'd0, 1'b1, 2'd1,
      36'sd1073741824, '0},
    // loads outside the current sizes must leave the stores alone
    '{STEP_CMD, OP_LOAD_A, 4'd1, 4'd0, 16'sh1234, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_LOAD_A, 4'd0, 4'd1, 16'sh5555, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_LOAD_B, 4'd1, 4'd0, 16'sh2222, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_LOAD_B, 4'd0, 4'd15, 16'sh7777, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_COMPUTE, 4'd1, 4'd0, 16'sh0000, CFG_ROWS, 5'd0, 1'b1, 2'd0, '0, '0},
    '{STEP_CMD, OP_COMPUTE, 4'd15, 4'd15, 16'shffff, CFG_ROWS, 5'd0, 1'b1, 2'd0, '0, '0},
    '{STEP_CMD, OP_SPARE, 4'd15, 4'd15, 16'shffff, CFG_ROWS, 5'd0, 1'b1, 2'd0, '0, '0},
    '{STEP_CMD, OP_COMPUTE, 4'd0, 4'd0, 16'sh0000, CFG_ROWS, 5'd0, 1'b1, 2'd1,
      36'sd1073741824, '0},
    '{STEP_CFG, OP_LOAD_A, 4'd0, 4'd0, 16'sh0000, CFG_SPARE, 5'd31, 1'b0, 2'd0, '0, '0},
    '{STEP_CFG, OP_LOAD_A, 4'd0, 4'd0, 16'sh0000, CFG_COLS, 5'd2, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_LOAD_B, 4'd0, 4'd1, 16'sh0100, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_COMPUTE, 4'd0, 4'd0, 16'sh0000, CFG_ROWS, 5'd0, 1'b1, 2'd2,
      36'sd1073741824, -36'sd8388608},
    '{STEP_CMD, OP_LOAD_A, 4'd0, 4'd0, 16'sh0000, CFG_ROWS, 5'd0, 1'b0, 2'd0, '0, '0},
    '{STEP_CMD, OP_COMPUTE, 4'd0, 4'd0, 16'sh0000, CFG_ROWS, 5'd0, 1'b1, 2'd2, '0, '0}
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  mme_cmd_if cmd_ch ();
  mme_res_if res_ch ();

  matrix_multiply_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  // size registers as last written, raw values
  logic [DIM_W-1:0] size_rows  = DIM_RESET;
  logic [DIM_W-1:0] size_inner = DIM_RESET;
  logic [DIM_W-1:0] size_cols  = DIM_RESET;

  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];
  bit                       a_set [DEPTH];
  bit                       b_set [DEPTH];

  row_sum_t pending_sums [$];
  step_t    shown_step;
  int       fail_count   = 0;
  int       useful_items = 0;
  int       burst_left   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int dim_in_use(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_W'(DIM_CAP)) return DIM_CAP;
    return int'(v);
  endfunction

  function automatic int flat_pos(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
    return int'(r) * MAX_DIM + int'(c);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic step_t make_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
                                     input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] e);
    step_t st;
    st = '0;
    st.kind = STEP_CMD;
    st.op = op;
    st.row = r;
    st.col = c;
    st.elem = e;
    return st;
  endfunction

  task automatic flag_fault(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endtask

  // model side of an accepted command word
  task automatic take_command();
    int       nr, nk, nc, j, k;
    longint   acc;
    row_sum_t rs;
    nr = dim_in_use(size_rows);
    nk = dim_in_use(size_inner);
    nc = dim_in_use(size_cols);
    case (cmd_ch.op)
      OP_LOAD_A: begin
        if (cmd_ch.row_index < nr && cmd_ch.col_index < nk)
          a_mem[flat_pos(cmd_ch.row_index, cmd_ch.col_index)] = cmd_ch.element;
      end
      OP_LOAD_B: begin
        if (cmd_ch.row_index < nk && cmd_ch.col_index < nc)
          b_mem[flat_pos(cmd_ch.row_index, cmd_ch.col_index)] = cmd_ch.element;
      end
      OP_COMPUTE: begin
        if (shown_step.typed) begin
          for (j = 0; j < int'(shown_step.n); j++) begin
            rs.sum = (j == 0) ? shown_step.s0 : shown_step.s1;
            rs.row = cmd_ch.row_index;
            rs.col = IDX_W'(j);
            rs.last = (j == int'(shown_step.n) - 1);
            pending_sums.push_back(rs);
          end
        end else if (cmd_ch.row_index < nr) begin
          for (j = 0; j < nc; j++) begin
            acc = 0;
            for (k = 0; k < nk; k++)
              acc += longint'(a_mem[flat_pos(cmd_ch.row_index, IDX_W'(k))]) *
                     longint'(b_mem[flat_pos(IDX_W'(k), IDX_W'(j))]);
            rs.sum = acc[SUM_W-1:0];
            rs.row = cmd_ch.row_index;
            rs.col = IDX_W'(j);
            rs.last = (j == nc - 1);
            pending_sums.push_back(rs);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    row_sum_t want;
    if (pending_sums.size() == 0) begin
      flag_fault($sformatf("unexpected result word: sum %0d row %0d col %0d last %0b",
                           $signed(res_ch.sum), res_ch.out_row, res_ch.out_col, res_ch.last));
    end else begin
      want = pending_sums.pop_front();
      if (want.sum !== res_ch.sum || want.row !== res_ch.out_row ||
          want.col !== res_ch.out_col || want.last !== res_ch.last) begin
        flag_fault($sformatf(
          "result mismatch: expected %0d r%0d c%0d l%0b, got %0d r%0d c%0d l%0b",
          $signed(want.sum), want.row, want.col, want.last,
          $signed(res_ch.sum), res_ch.out_row, res_ch.out_col, res_ch.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) take_command();
    if (!rst && res_ch.valid && res_ch.ready) check_result();
  end

  // sink stalls: open, shut and flickering stretches of random length
  initial begin
    rx_mode_e mode;
    int       seg_left;
    mode = RX_OPEN;
    seg_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 2));
        seg_left = (mode == RX_SHUT) ? $urandom_range(1, 16) : $urandom_range(4, 48);
      end
      seg_left--;
      case (mode)
        RX_OPEN: res_ch.ready <= 1'b1;
        RX_SHUT: res_ch.ready <= 1'b0;
        default: res_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("** matrix_multiply_engine_core: FAILED **");
    $finish;
  end

  task automatic send_word(input step_t st);
    int nr, nk, nc, gap;
    bit useful;
    nr = dim_in_use(size_rows);
    nk = dim_in_use(size_inner);
    nc = dim_in_use(size_cols);
    useful = 1'b0;
    case (st.op)
      OP_LOAD_A: begin
        if (st.row < nr && st.col < nk) begin
          a_set[flat_pos(st.row, st.col)] = 1'b1;
          useful = 1'b1;
        end
      end
      OP_LOAD_B: begin
        if (st.row < nk && st.col < nc) begin
          b_set[flat_pos(st.row, st.col)] = 1'b1;
          useful = 1'b1;
        end
      end
      OP_COMPUTE: useful = (st.row < nr);
      default: ;
    endcase
    if (useful) useful_items++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    shown_step = st;
    cmd_ch.valid     <= 1'b1;
    cmd_ch.op        <= st.op;
    cmd_ch.row_index <= st.row;
    cmd_ch.col_index <= st.col;
    cmd_ch.element   <= st.elem;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // stop sending and let the engine run dry
  task automatic settle();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    case (idx)
      CFG_ROWS:  size_rows = val;
      CFG_INNER: size_inner = val;
      CFG_COLS:  size_cols = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int    i, p, r, k, j, nr, nk, nc, start;
    bit    ok;
    step_t st;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_ROWS;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.op = OP_LOAD_A;
    cmd_ch.row_index = '0;
    cmd_ch.col_index = '0;
    cmd_ch.element = '0;
    shown_step = '0;
    for (i = 0; i < DEPTH; i++) begin
      a_mem[i] = '0;
      b_mem[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED_STEPS[i].kind == STEP_CFG) begin
        settle();
        cfg_write(DIRECTED_STEPS[i].reg_idx, DIRECTED_STEPS[i].reg_val);
      end else begin
        send_word(DIRECTED_STEPS[i]);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      cfg_write(CFG_ROWS, PHASE_ROWS[p]);
      cfg_write(CFG_INNER, PHASE_INNER[p]);
      cfg_write(CFG_COLS, PHASE_COLS[p]);
      nr = dim_in_use(size_rows);
      nk = dim_in_use(size_inner);
      nc = dim_in_use(size_cols);
      start = useful_items;
      while (useful_items - start < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 7) begin
          // row request preceded by whatever the row still needs, plus some rewrites
          r = $urandom_range(0, nr - 1);
          for (k = 0; k < nk; k++)
            if (!a_set[flat_pos(IDX_W'(r), IDX_W'(k))] || $urandom_range(0, 5) == 0)
              send_word(make_cmd(OP_LOAD_A, IDX_W'(r), IDX_W'(k), pick_element()));
          for (k = 0; k < nk; k++)
            for (j = 0; j < nc; j++)
              if (!b_set[flat_pos(IDX_W'(k), IDX_W'(j))] || $urandom_range(0, 5) == 0)
                send_word(make_cmd(OP_LOAD_B, IDX_W'(k), IDX_W'(j), pick_element()));
          send_word(make_cmd(OP_COMPUTE, IDX_W'(r), IDX_W'($urandom), ELEM_W'($urandom)));
        end else begin
          st = make_cmd(OP_W'($urandom_range(0, 3)), IDX_W'($urandom), IDX_W'($urandom),
                        pick_element());
          if (st.op == OP_COMPUTE && st.row < nr) begin
            ok = 1'b1;
            for (k = 0; k < nk; k++) begin
              if (!a_set[flat_pos(st.row, IDX_W'(k))]) ok = 1'b0;
              for (j = 0; j < nc; j++)
                if (!b_set[flat_pos(IDX_W'(k), IDX_W'(j))]) ok = 1'b0;
            end
            // never read an entry that was not written
            if (!ok) st.op = OP_SPARE;
          end
          send_word(st);
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("** matrix_multiply_engine_core: PASSED **");
    end else begin
      $display("** matrix_multiply_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
